### sv/v3ar_pkg.sv
// v3ar_pkg: types, constants and the CORDIC arctangent table for the
// 3D axis rotator. Used by v3ar_cell, v3ar_mix and vector3_axis_rotate.
package v3ar_pkg;

    localparam int COORD_W    = 32;   // signed Q16.16 coordinates
    localparam int ANGLE_W    = 16;   // binary angle, 2^ANGLE_W per turn
    localparam int TRIG_W     = 32;   // CORDIC datapath and trig values, Q2.30
    localparam int STEPS      = 28;   // CORDIC iterations, one per cell
    localparam int LO_W       = 16;   // low coordinate slice for split multiply
    localparam int PH_W       = COORD_W - LO_W + TRIG_W;
    localparam int PL_W       = LO_W + 1 + TRIG_W;
    localparam int Q_W        = PH_W + 1;
    localparam int ACC_W      = Q_W + 1;
    localparam int FRAC_DROP  = 14;   // Q.30 products back to Q.16

    localparam logic signed [TRIG_W-1:0] CORDIC_START = TRIG_W'(652032874);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE     = TRIG_W'(1) << 30;

    typedef enum logic [1:0] {
        MODE_X    = 2'd0,
        MODE_Y    = 2'd1,
        MODE_Z    = 2'd2,
        MODE_PASS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef struct packed {
        t_mode                      mode;
        logic signed [COORD_W-1:0]  in_x;
        logic signed [COORD_W-1:0]  in_y;
        logic signed [COORD_W-1:0]  in_z;
        logic        [ANGLE_W-1:0]  turn_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic signed [COORD_W-1:0]  out_z;
    } t_out_item;

    // One slot of the CORDIC cell chain: the vertex rides along with the angle state.
    typedef struct packed {
        logic                       valid;
        t_mode                      mode;
        t_quad                      quad;
        logic                       res_zero;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic signed [TRIG_W-1:0]   cx;
        logic signed [TRIG_W-1:0]   cy;
        logic signed [TRIG_W-1:0]   cz;
    } t_lane;

    // atan(2^-i) with 2^32 per turn, rounded to nearest
    function automatic logic signed [TRIG_W-1:0] arc_const(input int step);
        logic signed [TRIG_W-1:0] v;
        case (step)
            0:  v = TRIG_W'(536870912);
            1:  v = TRIG_W'(316933406);
            2:  v = TRIG_W'(167458907);
            3:  v = TRIG_W'(85004756);
            4:  v = TRIG_W'(42667331);
            5:  v = TRIG_W'(21354465);
            6:  v = TRIG_W'(10679838);
            7:  v = TRIG_W'(5340245);
            8:  v = TRIG_W'(2670163);
            9:  v = TRIG_W'(1335087);
            10: v = TRIG_W'(667544);
            11: v = TRIG_W'(333772);
            12: v = TRIG_W'(166886);
            13: v = TRIG_W'(83443);
            14: v = TRIG_W'(41722);
            15: v = TRIG_W'(20861);
            16: v = TRIG_W'(10430);
            17: v = TRIG_W'(5215);
            18: v = TRIG_W'(2608);
            19: v = TRIG_W'(1304);
            20: v = TRIG_W'(652);
            21: v = TRIG_W'(326);
            22: v = TRIG_W'(163);
            23: v = TRIG_W'(81);
            24: v = TRIG_W'(41);
            25: v = TRIG_W'(20);
            26: v = TRIG_W'(10);
            27: v = TRIG_W'(5);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/v3ar_cell.sv
// v3ar_cell: one CORDIC rotation step of the cell chain, registered.
// Depends on v3ar_pkg for the lane type and the arctangent table.
module v3ar_cell #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  v3ar_pkg::t_lane   i_lane,
    output v3ar_pkg::t_lane   o_lane
);

    localparam logic signed [v3ar_pkg::TRIG_W-1:0] ARC = v3ar_pkg::arc_const(STEP);

    logic signed [v3ar_pkg::TRIG_W-1:0] w_dx;
    logic signed [v3ar_pkg::TRIG_W-1:0] w_dy;
    v3ar_pkg::t_lane                    n_lane;
    v3ar_pkg::t_lane                    r_lane;

    assign w_dx = $signed(i_lane.cy) >>> STEP;
    assign w_dy = $signed(i_lane.cx) >>> STEP;

    always_comb begin
        n_lane = i_lane;
        if (!i_lane.cz[v3ar_pkg::TRIG_W-1]) begin
            n_lane.cx = i_lane.cx - w_dx;
            n_lane.cy = i_lane.cy + w_dy;
            n_lane.cz = i_lane.cz - ARC;
        end else begin
            n_lane.cx = i_lane.cx + w_dx;
            n_lane.cy = i_lane.cy - w_dy;
            n_lane.cz = i_lane.cz + ARC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

### sv/v3ar_mix.sv
// v3ar_mix: quadrant fold, split multiplies, rounding and saturation that turn
// cosine/sine from the cell chain into the rotated vertex. Depends on v3ar_pkg.
module v3ar_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  v3ar_pkg::t_lane       i_lane,
    output logic                  o_valid,
    output v3ar_pkg::t_out_item   o_res
);

    localparam int CW  = v3ar_pkg::COORD_W;
    localparam int TW  = v3ar_pkg::TRIG_W;
    localparam int LW  = v3ar_pkg::LO_W;
    localparam int PHW = v3ar_pkg::PH_W;
    localparam int PLW = v3ar_pkg::PL_W;
    localparam int QW  = v3ar_pkg::Q_W;
    localparam int AW  = v3ar_pkg::ACC_W;

    localparam logic signed [AW-1:0] ROUND_ADD = AW'(1) << (v3ar_pkg::FRAC_DROP - 1);
    localparam logic signed [AW-1:0] SAT_HI    = (AW'(1) << (CW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SAT_LO    = -(AW'(1) << (CW - 1));

    // high slice (signed) times trig value
    function automatic logic signed [PHW-1:0] mul_hi(
        input logic signed [CW-1:0] a,
        input logic signed [TW-1:0] c
    );
        logic signed [CW-LW-1:0] ah;
        ah = a[CW-1:LW];
        return ah * c;
    endfunction

    // low slice (unsigned) times trig value
    function automatic logic signed [PLW-1:0] mul_lo(
        input logic signed [CW-1:0] a,
        input logic signed [TW-1:0] c
    );
        logic signed [LW:0] al;
        al = $signed({1'b0, a[LW-1:0]});
        return al * c;
    endfunction

    // floor(a*c / 2^16) = hi + floor(lo / 2^16)
    function automatic logic signed [QW-1:0] join_q(
        input logic signed [PHW-1:0] ph,
        input logic signed [PLW-1:0] pl
    );
        logic signed [PLW-1:0] pl_sh;
        pl_sh = pl >>> LW;
        return QW'(ph) + QW'(pl_sh);
    endfunction

    function automatic logic signed [CW-1:0] finish(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        logic signed [CW-1:0] r;
        t = (acc + ROUND_ADD) >>> v3ar_pkg::FRAC_DROP;
        if (t > SAT_HI) begin
            r = SAT_HI[CW-1:0];
        end else if (t < SAT_LO) begin
            r = SAT_LO[CW-1:0];
        end else begin
            r = t[CW-1:0];
        end
        return r;
    endfunction

    // stage 1: folded cos/sin and the coordinate pair
    logic signed [TW-1:0] w_c0, w_s0, n_c, n_s;
    logic signed [CW-1:0] n_u, n_w;
    logic                 r1_valid;
    v3ar_pkg::t_mode      r1_mode;
    logic signed [CW-1:0] r1_x, r1_y, r1_z, r1_u, r1_w;
    logic signed [TW-1:0] r1_c, r1_s;

    // stage 2: partial products
    logic                 r2_valid;
    v3ar_pkg::t_mode      r2_mode;
    logic signed [CW-1:0] r2_x, r2_y, r2_z;
    logic signed [PHW-1:0] r2_uc_h, r2_ws_h, r2_us_h, r2_wc_h;
    logic signed [PLW-1:0] r2_uc_l, r2_ws_l, r2_us_l, r2_wc_l;

    // stage 3: Q.30 sums
    logic                 r3_valid;
    v3ar_pkg::t_mode      r3_mode;
    logic signed [CW-1:0] r3_x, r3_y, r3_z;
    logic signed [AW-1:0] r3_au, r3_aw;

    // stage 4: output register
    logic signed [CW-1:0] w_nu, w_nw;
    v3ar_pkg::t_out_item  n_res;
    logic                 r_out_valid;
    v3ar_pkg::t_out_item  r_res;

    always_comb begin
        w_c0 = i_lane.res_zero ? v3ar_pkg::TRIG_ONE : i_lane.cx;
        w_s0 = i_lane.res_zero ? '0 : i_lane.cy;
        case (i_lane.quad)
            v3ar_pkg::QUAD_0: begin
                n_c = w_c0;
                n_s = w_s0;
            end
            v3ar_pkg::QUAD_1: begin
                n_c = -w_s0;
                n_s = w_c0;
            end
            v3ar_pkg::QUAD_2: begin
                n_c = -w_c0;
                n_s = -w_s0;
            end
            default: begin
                n_c = w_s0;
                n_s = -w_c0;
            end
        endcase
        case (i_lane.mode)
            v3ar_pkg::MODE_X: begin
                n_u = i_lane.py;
                n_w = i_lane.pz;
            end
            v3ar_pkg::MODE_Y: begin
                n_u = i_lane.px;
                n_w = i_lane.pz;
            end
            default: begin
                n_u = i_lane.px;
                n_w = i_lane.py;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_lane.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= i_lane.mode;
            r1_x    <= i_lane.px;
            r1_y    <= i_lane.py;
            r1_z    <= i_lane.pz;
            r1_u    <= n_u;
            r1_w    <= n_w;
            r1_c    <= n_c;
            r1_s    <= n_s;

            r2_mode <= r1_mode;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_uc_h <= mul_hi(r1_u, r1_c);
            r2_uc_l <= mul_lo(r1_u, r1_c);
            r2_ws_h <= mul_hi(r1_w, r1_s);
            r2_ws_l <= mul_lo(r1_w, r1_s);
            r2_us_h <= mul_hi(r1_u, r1_s);
            r2_us_l <= mul_lo(r1_u, r1_s);
            r2_wc_h <= mul_hi(r1_w, r1_c);
            r2_wc_l <= mul_lo(r1_w, r1_c);

            r3_mode <= r2_mode;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_z    <= r2_z;
            r3_au   <= AW'(join_q(r2_uc_h, r2_uc_l)) - AW'(join_q(r2_ws_h, r2_ws_l));
            r3_aw   <= AW'(join_q(r2_us_h, r2_us_l)) + AW'(join_q(r2_wc_h, r2_wc_l));

            r_res   <= n_res;
        end
    end

    always_comb begin
        w_nu  = finish(r3_au);
        w_nw  = finish(r3_aw);
        n_res = '{out_x: r3_x, out_y: r3_y, out_z: r3_z};
        case (r3_mode)
            v3ar_pkg::MODE_X: begin
                n_res.out_y = w_nu;
                n_res.out_z = w_nw;
            end
            v3ar_pkg::MODE_Y: begin
                n_res.out_x = w_nu;
                n_res.out_z = w_nw;
            end
            v3ar_pkg::MODE_Z: begin
                n_res.out_x = w_nu;
                n_res.out_y = w_nw;
            end
            default: begin
                // pass-through mode: keep the vertex as it came in
                n_res.out_x = r3_x;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

### sv/vector3_axis_rotate.sv
// vector3_axis_rotate: rotates a Q16.16 vertex about the x, y or z axis by a binary angle.
// Top level; builds the CORDIC cell chain (v3ar_cell) and the output math (v3ar_mix).
//
// The block takes one vertex per clock and returns one rotated vertex per clock, in order.
// Each vertex passes through the row of CORDIC cells that turns the angle residual into
// cosine and sine, then through the back end (quadrant fold, split multiplies, sum, round
// and saturate into the output register). All stages advance together; a result held by
// i_stall freezes the whole pipe and raises o_stall. Mode 3 passes the vertex through;
// angles that are whole quarter turns rotate exactly.
module vector3_axis_rotate (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  v3ar_pkg::t_in_item    i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output v3ar_pkg::t_out_item   o_res
);

    localparam int NS = v3ar_pkg::STEPS;
    localparam int AW = v3ar_pkg::ANGLE_W;
    localparam int TW = v3ar_pkg::TRIG_W;

    logic                    w_en;
    logic [AW-3:0]           w_res;
    v3ar_pkg::t_lane         w_lane [0:NS];

    // advance unless the finished result is held
    assign o_stall = o_valid && i_stall;
    assign w_en    = !o_stall;

    assign w_res = i_req.turn_angle[AW-3:0];

    always_comb begin
        w_lane[0].valid    = i_valid;
        w_lane[0].mode     = i_req.mode;
        w_lane[0].quad     = v3ar_pkg::t_quad'(i_req.turn_angle[AW-1:AW-2]);
        w_lane[0].res_zero = (w_res == '0);
        w_lane[0].px       = i_req.in_x;
        w_lane[0].py       = i_req.in_y;
        w_lane[0].pz       = i_req.in_z;
        w_lane[0].cx       = v3ar_pkg::CORDIC_START;
        w_lane[0].cy       = '0;
        // residual below a quarter turn, in 2^32-per-turn units
        w_lane[0].cz       = $signed({2'b00, w_res, {(TW - AW){1'b0}}});
    end

    for (genvar g = 0; g < NS; g++) begin : g_cell
        v3ar_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_lane  (w_lane[g]),
            .o_lane  (w_lane[g+1])
        );
    end

    v3ar_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_lane  (w_lane[NS]),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_first_cell_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (w_lane[1].valid == $past(i_valid)))
        else $error("first cell lost or invented a request");

    a_chain_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_lane[NS].valid))
        else $error("cell chain moved while output held");

endmodule
